>>> design/afrd_pkg.sv
// ----------------------------------------------------------------------------
// afrd_pkg
// Shared types and constants of the animation frame run/skip/copy decoder.
// ----------------------------------------------------------------------------
package afrd_pkg;

  localparam int SIZE_W  = 17;
  localparam int POS_W   = 17;
  localparam int COUNT_W = 14;
  localparam int OFFS_W  = 16;
  localparam int BYTE_W  = 8;

  // Frame sizes above this act as this many bytes.
  localparam logic [SIZE_W-1:0] MAX_FRAME_BYTES = 17'd65536;
  localparam logic [SIZE_W-1:0] FRAME_SIZE_RST  = 17'd64000;
  localparam logic [POS_W-1:0]  POS_MAX         = 17'h1FFFF;

  // Opcode 0x80 escapes to a long op; long word bit 15 / bit 14 select the op.
  localparam logic [BYTE_W-1:0] OP_LONG      = 8'h80;
  localparam int                LONG_OP_BIT  = 15;
  localparam int                LONG_RUN_BIT = 14;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_EOF   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] src_byte;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [OFFS_W-1:0]  dest_offset;
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] run_length;
    logic               overrun;
    logic               last;
  } res_t;

endpackage

>>> design/afrd_in_reg.sv
// ----------------------------------------------------------------------------
// afrd_in_reg
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module afrd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  afrd_pkg::in_item_t in_item,
  input  logic               consume,
  output logic               item_valid,
  output afrd_pkg::in_item_t item
);

  logic               valid_r;
  afrd_pkg::in_item_t item_r;

  assign in_tready  = !valid_r || consume;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> design/afrd_parser.sv
// ----------------------------------------------------------------------------
// afrd_parser
// Op parser: phase, count, word low byte, write position and overrun flag,
// with one shared position adder for skips and for write/fill range checks.
// ----------------------------------------------------------------------------
module afrd_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [afrd_pkg::SIZE_W-1:0]       frame_size,
  input  logic                              step,
  input  afrd_pkg::in_item_t                item,
  output logic                              res_valid,
  output afrd_pkg::res_t                    res
);

  typedef enum logic [2:0] {
    PH_OPCODE     = 3'd0,
    PH_SRUN_COUNT = 3'd1,
    PH_SRUN_COLOR = 3'd2,
    PH_COPY       = 3'd3,
    PH_WORD_LO    = 3'd4,
    PH_WORD_HI    = 3'd5,
    PH_LRUN_COLOR = 3'd6
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [afrd_pkg::COUNT_W-1:0]      rem_r, rem_nxt;
  logic [afrd_pkg::BYTE_W-1:0]       wlo_r, wlo_nxt;
  logic [afrd_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic                              ovr_r, ovr_nxt;

  logic [afrd_pkg::SIZE_W-1:0]       eff_size;
  logic [afrd_pkg::POS_W:0]          sum;

  assign eff_size = (frame_size > afrd_pkg::MAX_FRAME_BYTES) ?
                    afrd_pkg::MAX_FRAME_BYTES : frame_size;

  always_comb begin
    phase_t                        ph;
    logic [afrd_pkg::COUNT_W-1:0]  rem;
    logic [afrd_pkg::BYTE_W-1:0]   wlo;
    logic [afrd_pkg::POS_W-1:0]    pos;
    logic                          ovr;
    logic [afrd_pkg::BYTE_W-1:0]   b;
    logic [15:0]                   word;
    logic [15:0]                   addend;
    logic                          do_add;
    logic                          emit;
    logic                          eof;

    // restart clears the frame before this byte is parsed
    ph  = item.restart ? PH_OPCODE : phase_r;
    rem = item.restart ? '0 : rem_r;
    wlo = item.restart ? '0 : wlo_r;
    pos = item.restart ? '0 : pos_r;
    ovr = item.restart ? 1'b0 : ovr_r;
    b    = item.src_byte;
    word = {b, wlo};

    phase_nxt = ph;
    rem_nxt   = rem;
    wlo_nxt   = wlo;
    ovr_nxt   = ovr;
    addend    = '0;
    do_add    = 1'b0;
    emit      = 1'b0;
    eof       = 1'b0;
    res            = '0;
    res.kind       = afrd_pkg::KIND_WRITE;
    res.value      = b;

    unique case (ph) inside
      PH_OPCODE: begin
        if (b == '0) begin
          phase_nxt = PH_SRUN_COUNT;
        end else if (!b[7]) begin
          rem_nxt   = {{(afrd_pkg::COUNT_W-afrd_pkg::BYTE_W){1'b0}}, b};
          phase_nxt = PH_COPY;
        end else if (b != afrd_pkg::OP_LONG) begin
          addend = {9'b0, b[6:0]};
          do_add = 1'b1;
        end else begin
          phase_nxt = PH_WORD_LO;
        end
      end
      PH_SRUN_COUNT: begin
        rem_nxt   = {{(afrd_pkg::COUNT_W-afrd_pkg::BYTE_W){1'b0}}, b};
        phase_nxt = PH_SRUN_COLOR;
      end
      PH_SRUN_COLOR, PH_LRUN_COLOR: begin
        phase_nxt = PH_OPCODE;
        rem_nxt   = '0;
        if (rem != '0) begin
          emit           = 1'b1;
          addend         = {2'b0, rem};
          res.kind       = afrd_pkg::KIND_FILL;
          res.run_length = rem;
        end
      end
      PH_COPY: begin
        if (rem <= afrd_pkg::COUNT_W'(1)) begin
          rem_nxt   = '0;
          phase_nxt = PH_OPCODE;
        end else begin
          rem_nxt = rem - afrd_pkg::COUNT_W'(1);
        end
        emit           = 1'b1;
        addend         = 16'd1;
        res.run_length = afrd_pkg::COUNT_W'(1);
      end
      PH_WORD_LO: begin
        wlo_nxt   = b;
        phase_nxt = PH_WORD_HI;
      end
      PH_WORD_HI: begin
        phase_nxt = PH_OPCODE;
        if (word == '0) begin
          eof = 1'b1;
        end else if (!word[afrd_pkg::LONG_OP_BIT]) begin
          addend = word;
          do_add = 1'b1;
        end else if (word[afrd_pkg::LONG_RUN_BIT]) begin
          rem_nxt   = word[afrd_pkg::COUNT_W-1:0];
          phase_nxt = PH_LRUN_COLOR;
        end else if (word[afrd_pkg::COUNT_W-1:0] != '0) begin
          rem_nxt   = word[afrd_pkg::COUNT_W-1:0];
          phase_nxt = PH_COPY;
        end
      end
      default: begin
        phase_nxt = PH_OPCODE;
      end
    endcase

    sum = {1'b0, pos} + {2'b0, addend};
    pos_nxt = pos;
    if (emit || do_add) begin
      pos_nxt = (sum > {1'b0, afrd_pkg::POS_MAX}) ? afrd_pkg::POS_MAX
                                                 : sum[afrd_pkg::POS_W-1:0];
    end
    if (emit) begin
      ovr_nxt         = ovr || (sum > {1'b0, eff_size});
      res.dest_offset = pos[afrd_pkg::OFFS_W-1:0];
      res.overrun     = ovr_nxt;
    end
    if (eof) begin
      res          = '0;
      res.kind     = afrd_pkg::KIND_EOF;
      res.overrun  = ovr;
      res.last     = 1'b1;
      rem_nxt      = '0;
      wlo_nxt      = '0;
      pos_nxt      = '0;
      ovr_nxt      = 1'b0;
    end
    res_valid = emit || eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      rem_r   <= '0;
      wlo_r   <= '0;
      pos_r   <= '0;
      ovr_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      wlo_r   <= wlo_nxt;
      pos_r   <= pos_nxt;
      ovr_r   <= ovr_nxt;
    end
  end

endmodule

>>> design/afrd_out_reg.sv
// ----------------------------------------------------------------------------
// afrd_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module afrd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  afrd_pkg::res_t res,
  output logic           slot_free,
  output logic           out_tvalid,
  input  logic           out_tready,
  output afrd_pkg::res_t out_res
);

  logic           valid_r;
  afrd_pkg::res_t res_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

>>> design/anim_frame_rle_delta_decoder.sv
// ----------------------------------------------------------------------------
// anim_frame_rle_delta_decoder
// Byte-serial decoder for run/skip/copy delta coded animation frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one compressed byte per transaction; in_tuser[0] = restart clears
//           the parser, write position and overrun flag before that byte.
//   out_* : zero or one result per input byte: single byte write, run fill
//           or end of frame (out_tlast). Writes or fills flagged in
//           out_tuser[2] reach past the frame size and must be dropped by
//           the consumer; the flag sticks until end of frame or restart.
//   cfg_* : cfg_we writes frame_size; only while the block is idle.
// Path: an accepted byte waits in the input register until the result slot
//   is free; it is then parsed and its result loaded for out_*.
// Throughput: one byte per cycle unless stalled, set by the single parser
//   state update (phase, count, position adder and range compare) per byte.
// Reset (rst_n low, synchronous): both pipeline registers empty, parser at
//   opcode phase, position and flag cleared, frame_size = 64000.
// Stall: a result waiting on out_tready stays put; one more byte can sit in
//   the input register, after which in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module anim_frame_rle_delta_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,    // frame_size
  // compressed byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] src_byte
  input  logic [0:0]  in_tuser,     // [0] restart
  // decoded results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [15:0] dest_offset, [23:16] value,
                                    // [37:24] run_length, [39:38] zero
  output logic [2:0]  out_tuser,    // [1:0] kind, [2] overrun
  output logic        out_tlast     // end of frame
);

  logic [afrd_pkg::SIZE_W-1:0] frame_size_r;

  afrd_pkg::in_item_t in_item, item;
  logic               item_valid;
  logic               consume;
  logic               slot_free;
  logic               res_valid;
  afrd_pkg::res_t     res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= afrd_pkg::FRAME_SIZE_RST;
    end else if (cfg_we) begin
      frame_size_r <= cfg_wdata;
    end
  end

  assign in_item.src_byte = in_tdata;
  assign in_item.restart  = in_tuser[0];

  // the parser steps whenever a byte is waiting and the result slot can
  // take whatever it produces
  assign consume = item_valid && slot_free;

  afrd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  afrd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_size (frame_size_r),
    .step       (consume),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res)
  );

  afrd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume && res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {2'b00, out_res.run_length, out_res.value, out_res.dest_offset};
  assign out_tuser = {out_res.overrun, out_res.kind};
  assign out_tlast = out_res.last;

endmodule

>>> design/afrd_checker.sv
// ----------------------------------------------------------------------------
// afrd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module afrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a fresh result comes from a byte accepted before it, via the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transaction");

  // end of frame carries an empty payload and its own kind
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == '0 &&
                                out_tuser[1:0] == afrd_pkg::KIND_EOF)
    else $error("malformed end-of-frame result");

endmodule

bind anim_frame_rle_delta_decoder afrd_checker u_afrd_checker (.*);
